>>> sv/mrsr_pkg.sv
// Package for the Modbus RTU slave responder: response descriptor, config
// bundle, protocol codes and the byte-wide CRC-16 update.
// No dependencies.
`default_nettype none
package mrsr_pkg;

    localparam int FRAME_KEEP = 8;
    localparam int CRC_SPAN   = 6;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = 1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  FN_WRITE = 8'h06;
    localparam logic [7:0]  FN_READ  = 8'h03;
    localparam logic [7:0]  FN_MULTI = 8'h10;
    localparam logic [7:0]  RD_BYTE_COUNT = 8'h02;

    localparam logic [2:0] CFG_SLAVE_ID     = 3'd0;
    localparam logic [2:0] CFG_MOTOR_ADDR   = 3'd1;
    localparam logic [2:0] CFG_SWITCH_ADDR  = 3'd2;
    localparam logic [2:0] CFG_MOTOR_VALUE  = 3'd3;
    localparam logic [2:0] CFG_SWITCH_VALUE = 3'd4;

    localparam logic [2:0] IDX_CRC_LO = 3'd5;
    localparam logic [2:0] IDX_RD_END = 3'd6;
    localparam logic [2:0] IDX_WR_END = 3'd7;

    typedef struct packed {
        logic [7:0]  slave_id;
        logic [15:0] motor_addr;
        logic [15:0] switch_addr;
        logic [15:0] motor_value;
        logic [15:0] switch_value;
    } t_cfg;

    typedef struct packed {
        logic            is_read;
        logic [7:0][7:0] bytes;
    } t_desc;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> sv/mrsr_front.sv
// Receive side: frame store, running CRC-16 and frame classification.
// Depends on mrsr_pkg; pushes response descriptors into mrsr_queue.
`default_nettype none
module mrsr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mrsr_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_frame_end,
    input  wire logic          i_q_full,
    output logic               o_push,
    output mrsr_pkg::t_desc    o_desc
);
    import mrsr_pkg::*;

    logic [3:0]      r_count;
    logic [15:0]     r_crc;
    logic [7:0][7:0] r_store;
    logic            acc;
    logic            full_frame;
    logic [7:0]      last_byte;
    logic [15:0]     rcv_crc;
    logic [15:0]     reg_addr;
    logic            frame_ok;
    logic            hit_motor;
    logic            hit_switch;
    logic [15:0]     rd_value;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 4'd0;
            r_crc   <= CRC_INIT;
        end else if (acc) begin
            if (i_frame_end) begin
                r_count <= 4'd0;
                r_crc   <= CRC_INIT;
            end else if (!r_count[3]) begin
                r_count <= r_count + 4'd1;
                if (r_count < 4'(CRC_SPAN)) begin
                    r_crc <= crc_byte(r_crc, i_byte);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !r_count[3]) begin
            r_store[r_count[2:0]] <= i_byte;
        end
    end

    always_comb begin
        full_frame = (r_count == 4'd7) || r_count[3];
        last_byte  = r_count[3] ? r_store[7] : i_byte;
        rcv_crc    = {last_byte, r_store[6]};
        reg_addr   = {r_store[2], r_store[3]};
        frame_ok   = full_frame && (r_store[0] == i_cfg.slave_id) && (rcv_crc == r_crc);
        hit_motor  = reg_addr == i_cfg.motor_addr;
        hit_switch = reg_addr == i_cfg.switch_addr;
        rd_value   = hit_motor ? i_cfg.motor_value : i_cfg.switch_value;

        o_desc.is_read = 1'b0;
        o_desc.bytes   = {last_byte, r_store[6:0]};
        o_push         = 1'b0;
        if (acc && i_frame_end && frame_ok) begin
            if (r_store[1] == FN_WRITE) begin
                o_push = 1'b1;
            end else if (r_store[1] == FN_READ && (hit_motor || hit_switch)) begin
                o_push         = 1'b1;
                o_desc.is_read = 1'b1;
                o_desc.bytes   = {24'h000000, rd_value[7:0], rd_value[15:8],
                                  RD_BYTE_COUNT, FN_READ, i_cfg.slave_id};
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/mrsr_queue.sv
// Two-entry descriptor queue between the receive and transmit sides.
// Depends on mrsr_pkg for the descriptor type and depth.
`default_nettype none
module mrsr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mrsr_pkg::t_desc i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output mrsr_pkg::t_desc     o_data
);
    import mrsr_pkg::*;

    t_desc           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_fill;
    logic            do_pop;

    assign o_full  = r_fill == (Q_AW+1)'(Q_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && do_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> sv/mrsr_back.sv
// Transmit side: walks one descriptor out byte by byte, appending the
// CRC-16 for read answers. Depends on mrsr_pkg; pops from mrsr_queue.
`default_nettype none
module mrsr_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire mrsr_pkg::t_desc i_q_data,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [7:0]          o_byte,
    output logic                o_last
);
    import mrsr_pkg::*;

    logic        r_act;
    t_desc       r_desc;
    logic [2:0]  r_idx;
    logic [15:0] r_crc;
    logic        hs;

    assign o_valid = r_act;
    assign hs      = r_act && i_ready;

    always_comb begin
        o_byte = r_desc.bytes[r_idx];
        if (r_desc.is_read && r_idx == IDX_CRC_LO) begin
            o_byte = r_crc[7:0];
        end else if (r_desc.is_read && r_idx == IDX_RD_END) begin
            o_byte = r_crc[15:8];
        end
        o_last = r_desc.is_read ? (r_idx == IDX_RD_END) : (r_idx == IDX_WR_END);
        o_pop  = i_q_valid && (!r_act || (hs && o_last));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (o_pop) begin
            r_act <= 1'b1;
        end else if (hs && o_last) begin
            r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_q_data;
            r_idx  <= 3'd0;
            r_crc  <= CRC_INIT;
        end else if (hs) begin
            r_idx <= r_idx + 3'd1;
            if (r_desc.is_read && r_idx < IDX_CRC_LO) begin
                r_crc <= crc_byte(r_crc, o_byte);
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/modbus_rtu_slave_responder_unit.sv
// Modbus RTU slave responder: one received byte per cycle unless the queue is full,
// CRC-16 checked; echo for function 0x06, register read answer for function 0x03.
// A two-entry descriptor queue decouples the receive and transmit sides.
// Throughput: one byte per cycle in and out while neither side is stalled.
// Reset (synchronous, active low) clears counters, CRC, queue and config to defaults.
`default_nettype none
module modbus_rtu_slave_responder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // receive stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tlast,   // frame_end
    // response stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] tx_byte
    output logic             m_axis_tlast    // tx_last
);
    import mrsr_pkg::*;

    t_cfg  r_cfg;
    logic  q_full;
    logic  q_push;
    t_desc q_in;
    logic  q_pop;
    logic  q_valid;
    t_desc q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_id     <= 8'd1;
            r_cfg.motor_addr   <= 16'd0;
            r_cfg.switch_addr  <= 16'd1;
            r_cfg.motor_value  <= 16'd0;
            r_cfg.switch_value <= 16'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SLAVE_ID:     r_cfg.slave_id     <= i_cfg_data[7:0];
                CFG_MOTOR_ADDR:   r_cfg.motor_addr   <= i_cfg_data;
                CFG_SWITCH_ADDR:  r_cfg.switch_addr  <= i_cfg_data;
                CFG_MOTOR_VALUE:  r_cfg.motor_value  <= i_cfg_data;
                CFG_SWITCH_VALUE: r_cfg.switch_value <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mrsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_frame_end (s_axis_tlast),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_desc      (q_in)
    );

    mrsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    mrsr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule
`default_nettype wire
